// ===== rtl/film_print_color_grade_macros.svh =====
// Assertion macros for the film print color grade block.
// Used by rtl/film_print_color_grade.sv; expects clk and rst_n in scope.
`ifndef FILM_PRINT_COLOR_GRADE_MACROS_SVH
`define FILM_PRINT_COLOR_GRADE_MACROS_SVH

// check a property while out of reset
`define FPCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define FPCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fpcg_pkg.sv =====
// Shared types, register indexes and fixed-point helpers for the color grade.
// No dependencies.
package fpcg_pkg;

  localparam int EXP_TABLE_DEPTH_DEF = 256;

  localparam int QW = 20;
  typedef logic signed [QW-1:0] q_t;

  localparam logic signed [63:0] Q_ONE = 64'sd65536;
  localparam logic signed [63:0] Q_MAX = 64'sd524287;
  localparam logic signed [63:0] Q_MIN = -64'sd524288;
  localparam logic signed [63:0] KNEE  = 64'sd49152;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 10;
  localparam logic [CFG_AW-1:0] REG_TONE_CURVE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_COLOR_GAIN = 3'd1;
  localparam logic [CFG_AW-1:0] REG_NEUTRALIZE = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BLACK_POINT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ROLLOFF = 3'd4;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic q_t sat_q(input logic signed [63:0] v);
    q_t r;
    if (v > Q_MAX) r = q_t'(Q_MAX);
    else if (v < Q_MIN) r = q_t'(Q_MIN);
    else r = q_t'(v);
    return r;
  endfunction

  function automatic q_t luma(input q_t a, input q_t b, input q_t c);
    logic signed [63:0] s;
    s = 64'(a) * 64'sd19595 + 64'(b) * 64'sd38470 + 64'(c) * 64'sd7471;
    return q_t'(rnd(s, 16));
  endfunction

endpackage

// ===== rtl/film_print_color_grade.sv =====
// Film print color grade: thirteen-stage pixel pipeline with config registers.
// Depends on fpcg_pkg and film_print_color_grade_macros.svh.
//
// Usage:
//   Input channel in_*: one RGBA pixel per transaction, tlast marks the last
//   pixel of an image. Output channel out_*: the graded pixel, alpha and
//   tlast copied. Config port cfg_*: write enable, register index, data;
//   write only while the pipeline is empty.
//   Throughput: one pixel per cycle unless stalled; thirteen register stages
//   (luma, blend, saturation, black point, two-multiply smoothstep, roll-off
//   table lookup, byte conversion) each hold one pixel.
//   Reset: all stage valid bits clear, registers take their defaults
//   (tone 0, gain 256, neutralize 0, black point 0, roll-off 0).
//   Stall: when out_tready is low with a result waiting, the whole pipeline
//   holds and in_tready drops; nothing is lost or repeated.
//   The roll-off table is a constant of EXP_TABLE_DEPTH entries.
`include "film_print_color_grade_macros.svh"
module film_print_color_grade #(
  parameter int EXP_TABLE_DEPTH = fpcg_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                        out_tlast,
  input  logic                        cfg_wr_en,
  input  logic [fpcg_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [fpcg_pkg::CFG_DW-1:0] cfg_wdata
);
  import fpcg_pkg::*;

  localparam int NST = 13;
  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  typedef logic [16:0] tab_t [EXP_TABLE_DEPTH];

  // shift-subtract quotient, evaluated only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    logic signed [63:0] e;
    logic [63:0] term;
    logic [63:0] p;
    e = 64'sd0;
    term = 64'd1 << 31;
    p = 64'd1 << 31;
    for (int k = 0; k < 64; k++) begin
      if (term != 64'd0) begin
        if (k[0]) e = e - $signed(term);
        else e = e + $signed(term);
        term = udiv64(term * 64'd8, 64'(EXP_TABLE_DEPTH) * 64'(k + 1));
      end
    end
    if (e < 0) e = 64'sd0;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      if (i > 0) p = (p * $unsigned(e) + (64'd1 << 30)) >> 31;
      t[i] = 17'(64'd65536 - ((p + (64'd1 << 14)) >> 15));
    end
    return t;
  endfunction

  localparam tab_t ROLL_TAB = build_tab();

  logic signed [9:0] tone_r;
  logic [9:0]        gain_r;
  logic [8:0]        neu_r;
  logic signed [9:0] bp_r;
  logic [8:0]        ro_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r <= '0;
      gain_r <= 10'd256;
      neu_r  <= '0;
      bp_r   <= '0;
      ro_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TONE_CURVE:  tone_r <= cfg_wdata;
        REG_COLOR_GAIN:  gain_r <= cfg_wdata;
        REG_NEUTRALIZE:  neu_r  <= cfg_wdata[8:0];
        REG_BLACK_POINT: bp_r   <= cfg_wdata;
        REG_ROLLOFF:     ro_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic           en;
  logic [NST-1:0] vld_r;
  q_t             c_r   [NST][3];
  q_t             c_nxt [NST][3];
  logic [7:0]     alpha_r [NST];
  logic           last_r  [NST];
  q_t                 gray_r, gray1_r;
  logic signed [23:0] sq_r [3], sq_nxt [3];
  logic signed [47:0] np_r [3], np_nxt [3];
  q_t                 s_r  [3], s_nxt  [3];
  logic [26:0]        u_r  [3], u_nxt  [3];
  logic [2:0]         above_r, above_nxt, above2_r;
  logic [2:0]         big_r, big_nxt;
  logic [IDX_W-1:0]   idx_r [3], idx_nxt [3];
  logic [7:0]         ob_r [3], ob_nxt [3];

  assign en = !vld_r[NST-1] || out_tready;
  assign in_tready = en;

  always_comb begin
    logic signed [63:0] v;
    logic signed [63:0] w;
    logic signed [63:0] sc;
    logic [7:0] x;
    sc = Q_ONE;
    for (int j = 0; j < 3; j++) begin
      x = in_tdata[8*j +: 8];
      c_nxt[0][j] = q_t'(20'(x) * 20'd257 + 20'(x[7]));
      c_nxt[1][j] = c_r[0][j];
      if (neu_r != 9'd0)
        c_nxt[2][j] = sat_q(64'(c_r[1][j]) +
                            rnd((64'(gray1_r) - 64'(c_r[1][j])) * 64'(neu_r), 8));
      else c_nxt[2][j] = c_r[1][j];
      c_nxt[3][j] = c_r[2][j];
      if (gain_r != 10'd256)
        c_nxt[4][j] = sat_q(64'(gray_r) +
                            rnd((64'(c_r[3][j]) - 64'(gray_r)) * 64'(gain_r), 8));
      else c_nxt[4][j] = c_r[3][j];
      if (bp_r > 0)
        c_nxt[5][j] = sat_q(64'(c_r[4][j]) + rnd(64'(bp_r) * 64'sd6554, 8));
      else if (bp_r < 0) begin
        sc = Q_ONE - rnd(-64'(bp_r) * 64'sd19661, 8);
        c_nxt[5][j] = sat_q(rnd(64'(c_r[4][j]) * sc, 16));
      end else c_nxt[5][j] = c_r[4][j];
      c_nxt[6][j] = c_r[5][j];
      sq_nxt[j] = 24'(rnd(64'(c_r[5][j]) * 64'(c_r[5][j]), 16));
      np_nxt[j] = 48'((64'sd32768 - 64'(c_r[5][j])) * (-64'(tone_r) * 64'sd13107));
      s_nxt[j] = sat_q(rnd(64'(sq_r[j]) * (64'sd196608 - 64'sd2 * 64'(c_r[6][j])), 16));
      if (tone_r < 0) c_nxt[7][j] = sat_q(64'(c_r[6][j]) + rnd(64'(np_r[j]), 24));
      else c_nxt[7][j] = c_r[6][j];
      if (tone_r > 0)
        c_nxt[8][j] = sat_q(64'(c_r[7][j]) +
                            rnd((64'(s_r[j]) - 64'(c_r[7][j])) * 64'(tone_r), 8));
      else c_nxt[8][j] = c_r[7][j];
      c_nxt[9][j] = c_r[8][j];
      above_nxt[j] = (ro_r != 9'd0) && (64'(c_r[8][j]) > KNEE);
      u_nxt[j] = 27'(rnd((64'(c_r[8][j]) - KNEE) * 64'sd4 *
                         (64'sd256 + 64'sd3 * 64'(ro_r)), 8));
      c_nxt[10][j] = c_r[9][j];
      v = rnd(64'(u_r[j]) * 64'(EXP_TABLE_DEPTH), 19);
      big_nxt[j] = v >= 64'(EXP_TABLE_DEPTH);
      idx_nxt[j] = v[IDX_W-1:0];
      if (above2_r[j]) begin
        w = big_r[j] ? Q_ONE : 64'(ROLL_TAB[idx_r[j]]);
        c_nxt[11][j] = q_t'(KNEE + ((w + 64'sd2) >>> 2));
      end else c_nxt[11][j] = c_r[10][j];
      c_nxt[12][j] = c_r[11][j];
      w = 64'(c_r[11][j]);
      if (w < 0) w = 64'sd0;
      if (w > Q_ONE) w = Q_ONE;
      ob_nxt[j] = 8'((w * 64'sd255 + 64'sd32768) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NST-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r[0] <= in_tdata[31:24];
      last_r[0]  <= in_tlast;
      for (int k = 1; k < NST; k++) begin
        alpha_r[k] <= alpha_r[k-1];
        last_r[k]  <= last_r[k-1];
      end
      for (int k = 0; k < NST; k++)
        for (int j = 0; j < 3; j++) c_r[k][j] <= c_nxt[k][j];
      gray1_r  <= luma(c_r[0][0], c_r[0][1], c_r[0][2]);
      gray_r   <= luma(c_r[2][0], c_r[2][1], c_r[2][2]);
      sq_r     <= sq_nxt;
      np_r     <= np_nxt;
      s_r      <= s_nxt;
      u_r      <= u_nxt;
      above_r  <= above_nxt;
      above2_r <= above_r;
      big_r    <= big_nxt;
      idx_r    <= idx_nxt;
      ob_r     <= ob_nxt;
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {alpha_r[NST-1], ob_r[2], ob_r[1], ob_r[0]};
  assign out_tlast  = last_r[NST-1];

  `FPCG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")
  `FPCG_ASSERT(a_ready_rule, in_tready == (!out_tvalid || out_tready), "ready mismatch")
  `FPCG_ASSERT(a_stall_hold, (vld_r[0] && !en) |=> vld_r[0], "stage lost on stall")
endmodule
